[src/assert_macros.svh]
// Assertion macros shared by the shift buffer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, masked while reset is low.
`define SBIR_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Same-cycle implication, masked while reset is low.
`define SBIR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is low.
`define SBIR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/sbir_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbir_pkg
// Types, command codes and defaults for the shift buffer insert/remove block.
// ---------------------------------------------------------------------------
package sbir_pkg;

    // Field widths of the item ports
    localparam int CMD_W  = 2;
    localparam int POS_W  = 8;
    localparam int CHAR_W = 8;
    localparam int REV_W  = 32;

    // Default buffer length
    localparam int BUFFER_DEPTH_DEF = 256;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_NULL   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

    // Controller states
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic execute;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_stall;
    } dp_stat_t;

endpackage

[src/sbir_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbir_ctrl
// Controller: takes an item in IDLE, runs it in EXEC once the output
// register is free.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sbir_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sbir_pkg::dp_stat_t  stat,
    output sbir_pkg::ctrl_cmd_t ctrl
);
    import sbir_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!stat.out_stall) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        s_ready      = 1'b0;
        ctrl.capture = 1'b0;
        ctrl.execute = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready      = 1'b1;
                ctrl.capture = s_valid;
            end
            ST_EXEC: begin
                ctrl.execute = !stat.out_stall;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    `SBIR_ASSERT_NXT(a_capture_to_exec, aclk, aresetn, ctrl.capture, state_reg == ST_EXEC, "capture not followed by EXEC")
    `SBIR_ASSERT_IMP(a_exec_free, aclk, aresetn, ctrl.execute, !stat.out_stall && state_reg == ST_EXEC, "execute while output stalled")

endmodule

[src/sbir_dp.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbir_dp
// Datapath: input registers, row of character cells with left/right shift,
// revision counter and the output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sbir_dp #(
    parameter int BUFFER_DEPTH = sbir_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  sbir_pkg::ctrl_cmd_t          ctrl,
    output sbir_pkg::dp_stat_t           stat,
    input  logic [sbir_pkg::CMD_W-1:0]   s_cmd,
    input  logic [sbir_pkg::POS_W-1:0]   s_position,
    input  logic [sbir_pkg::CHAR_W-1:0]  s_character,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [sbir_pkg::CHAR_W-1:0]  m_read_char,
    output logic [sbir_pkg::REV_W-1:0]   m_revision_count,
    output logic                         m_bad_position
);
    import sbir_pkg::*;

    localparam int IDX_W = $clog2(BUFFER_DEPTH);

    logic [CMD_W-1:0]  cmd_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [CHAR_W-1:0] char_reg;

    logic [CHAR_W-1:0] cells_reg  [BUFFER_DEPTH];
    logic [CHAR_W-1:0] cells_next [BUFFER_DEPTH];

    logic [REV_W-1:0]  revision_reg;
    logic [REV_W-1:0]  revision_next;

    logic              m_valid_reg;
    logic              m_valid_next;
    logic [CHAR_W-1:0] rd_char_reg;
    logic [REV_W-1:0]  rev_out_reg;
    logic              bad_reg;

    logic              in_range;
    logic              pos_ok;
    logic              do_write;
    logic [IDX_W-1:0]  rd_idx;
    logic [CHAR_W-1:0] rd_char;

    // Input item register
    always_ff @(posedge aclk) begin
        if (ctrl.capture) begin
            cmd_reg  <= s_cmd;
            pos_reg  <= s_position;
            char_reg <= s_character;
        end
    end

    // Position check; null never looks at the position
    assign in_range = (32'(pos_reg) < 32'(BUFFER_DEPTH));
    assign pos_ok   = (cmd_reg == CMD_NULL) || in_range;
    assign do_write = ctrl.execute && pos_ok;

    // Cell row: each cell picks keep, left neighbour, right neighbour, new char or zero
    for (genvar i = 0; i < BUFFER_DEPTH; i++) begin : g_cell
        localparam logic [31:0] IDX = 32'(i);

        always_comb begin
            cells_next[i] = cells_reg[i];
            if (do_write) begin
                case (cmd_reg)
                    CMD_INSERT: begin
                        if (IDX == 32'(pos_reg)) begin
                            cells_next[i] = char_reg;
                        end else if (IDX > 32'(pos_reg)) begin
                            if (i > 0) begin
                                cells_next[i] = cells_reg[(i > 0) ? i - 1 : 0];
                            end
                        end
                    end
                    CMD_REMOVE: begin
                        if (i == BUFFER_DEPTH - 1) begin
                            cells_next[i] = '0;
                        end else if (IDX >= 32'(pos_reg)) begin
                            cells_next[i] =
                                cells_reg[(i < BUFFER_DEPTH - 1) ? i + 1 : i];
                        end
                    end
                    default: begin
                        cells_next[i] = cells_reg[i];
                    end
                endcase
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                cells_reg[i] <= '0;
            end else begin
                cells_reg[i] <= cells_next[i];
            end
        end
    end

    // Read select, only used when the position is in range
    assign rd_idx  = IDX_W'(pos_reg);
    assign rd_char = cells_reg[rd_idx];

    // Revision counter
    always_comb begin
        revision_next = revision_reg;
        if (do_write && cmd_reg != CMD_READ) begin
            revision_next = revision_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            revision_reg <= '0;
        end else begin
            revision_reg <= revision_next;
        end
    end

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (ctrl.execute) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.execute) begin
            rd_char_reg <= (cmd_reg == CMD_READ && in_range) ? rd_char : '0;
            rev_out_reg <= revision_next;
            bad_reg     <= !pos_ok;
        end
    end

    assign stat.out_stall   = m_valid_reg && !m_ready;
    assign m_valid          = m_valid_reg;
    assign m_read_char      = rd_char_reg;
    assign m_revision_count = rev_out_reg;
    assign m_bad_position   = bad_reg;

    `SBIR_ASSERT_NXT(a_exec_gives_item, aclk, aresetn, ctrl.execute, m_valid_reg, "executed item not presented")
    `SBIR_ASSERT_IMP(a_bad_no_char, aclk, aresetn, m_valid_reg && bad_reg, rd_char_reg == '0, "bad position with non-zero char")
    `SBIR_ASSERT_NXT(a_bad_keeps_rev, aclk, aresetn, ctrl.execute && !pos_ok, $stable(revision_reg), "rejected item changed revision")

endmodule

[src/shift_buffer_insert_remove_top.sv]
`timescale 1ns / 1ps
// An accepted item is captured into the input registers and executed in EXEC, and the
// result is registered in the output register; no new item is taken before it executes.
// The controller alternates capture and execute; execute waits while output is held.
// The cell row shifts the cells from the position upward in the execute cycle.
// Reset (aresetn low, synchronous) clears every cell, the revision counter,
// the output valid flag and the controller state at once; no clearing pass.
// ---------------------------------------------------------------------------
// shift_buffer_insert_remove_top
// Character buffer with insert, remove, null and read commands plus a
// wrapping revision counter.
// ---------------------------------------------------------------------------
module shift_buffer_insert_remove_top #(
    parameter int BUFFER_DEPTH = sbir_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [sbir_pkg::CMD_W-1:0]   s_cmd,
    input  logic [sbir_pkg::POS_W-1:0]   s_position,
    input  logic [sbir_pkg::CHAR_W-1:0]  s_character,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [sbir_pkg::CHAR_W-1:0]  m_read_char,
    output logic [sbir_pkg::REV_W-1:0]   m_revision_count,
    output logic                         m_bad_position
);
    import sbir_pkg::*;

    ctrl_cmd_t ctrl;
    dp_stat_t  stat;

    // Controller
    sbir_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    // Datapath
    sbir_dp #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .ctrl             (ctrl),
        .stat             (stat),
        .s_cmd            (s_cmd),
        .s_position       (s_position),
        .s_character      (s_character),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_read_char      (m_read_char),
        .m_revision_count (m_revision_count),
        .m_bad_position   (m_bad_position)
    );

endmodule
